// ===== sv/cwd_pkg.sv =====
`timescale 1ns / 1ps

package cwd_pkg;

  // CRC-8, MSB first, no reflection, no final XOR
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_TOP  = 8'h80;

  // Words per frame: configured count is capped at this value
  localparam int unsigned MAX_WORDS = 16;

  localparam int unsigned CNT_W   = 5;  // word counter and word_count register
  localparam int unsigned EFF_W   = 7;  // holds values up to 127
  localparam int unsigned POS_W   = 4;
  localparam logic [CNT_W-1:0] WORD_COUNT_RST = 5'd9;

  // Position of the next byte within its three-byte group
  typedef enum logic [1:0] {
    PH_HIGH  = 2'd0,
    PH_LOW   = 2'd1,
    PH_CHECK = 2'd2
  } phase_t;

  typedef struct packed {
    logic [15:0]      word_value;
    logic [POS_W-1:0] word_position;
    logic             crc_ok;
    logic             last_word;
  } result_t;

  // One byte through the CRC, bitwise
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                           input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int b = 0; b < 8; b++) begin
      if ((c & CRC_TOP) != 8'h00) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/cwd_if.sv =====
`timescale 1ns / 1ps

// Byte channel into the deframer
interface cwd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

// Word channel out of the deframer
interface cwd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] word_value;
  logic [3:0]  word_position;
  logic        crc_ok;
  logic        last_word;

  modport source (output valid, output word_value, output word_position,
                  output crc_ok, output last_word, input ready);
  modport sink   (input valid, input word_value, input word_position,
                  input crc_ok, input last_word, output ready);
endinterface

// ===== sv/cwd_core.sv =====
`timescale 1ns / 1ps

module cwd_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [cwd_pkg::CNT_W-1:0] cfg_wr_data,
  input  logic                     acc,
  input  logic [7:0]               rx_byte,
  input  logic                     frame_start,
  output logic                     res_valid,
  output cwd_pkg::result_t         res
);

  cwd_pkg::phase_t           phase_r, phase_nxt, phase_cur;
  logic [7:0]                first_r, first_nxt;
  logic [7:0]                second_r, second_nxt;
  logic [7:0]                crc_r, crc_nxt, crc_cur;
  logic [cwd_pkg::CNT_W-1:0] cnt_r, cnt_nxt, cnt_cur;
  logic                      done_r, done_nxt, done_cur;
  logic [cwd_pkg::CNT_W-1:0] word_count_r;
  logic [cwd_pkg::EFF_W-1:0] eff_count;
  logic [cwd_pkg::EFF_W-1:0] cnt_inc;
  logic                      ok;
  logic                      last;

  // Effective word count: zero reads as one, capped at the maximum
  always_comb begin
    eff_count = {{(cwd_pkg::EFF_W-cwd_pkg::CNT_W){1'b0}}, word_count_r};
    if (word_count_r == '0) begin
      eff_count = cwd_pkg::EFF_W'(1);
    end
    if (eff_count > cwd_pkg::EFF_W'(cwd_pkg::MAX_WORDS)) begin
      eff_count = cwd_pkg::EFF_W'(cwd_pkg::MAX_WORDS);
    end
  end

  // Frame start clears the group state before the byte is taken
  always_comb begin
    phase_cur = phase_r;
    crc_cur   = crc_r;
    cnt_cur   = cnt_r;
    done_cur  = done_r;
    if (frame_start) begin
      phase_cur = cwd_pkg::PH_HIGH;
      crc_cur   = cwd_pkg::CRC_INIT;
      cnt_cur   = '0;
      done_cur  = 1'b0;
    end
  end

  assign cnt_inc = {{(cwd_pkg::EFF_W-cwd_pkg::CNT_W){1'b0}}, cnt_cur} + cwd_pkg::EFF_W'(1);
  assign ok      = (crc_cur == rx_byte);
  assign last    = !ok || (cnt_inc >= eff_count);

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      phase_nxt = phase_cur;
      if (!done_cur) begin
        case (phase_cur)
          cwd_pkg::PH_HIGH: phase_nxt = cwd_pkg::PH_LOW;
          cwd_pkg::PH_LOW:  phase_nxt = cwd_pkg::PH_CHECK;
          default:          phase_nxt = cwd_pkg::PH_HIGH;
        endcase
      end
    end
  end

  // Data path and result
  always_comb begin
    first_nxt  = first_r;
    second_nxt = second_r;
    crc_nxt    = crc_r;
    cnt_nxt    = cnt_r;
    done_nxt   = done_r;
    res_valid  = 1'b0;
    res.word_value    = {first_r, second_r};
    res.word_position = cnt_cur[cwd_pkg::POS_W-1:0];
    res.crc_ok        = ok;
    res.last_word     = last;
    if (acc) begin
      crc_nxt  = crc_cur;
      cnt_nxt  = cnt_cur;
      done_nxt = done_cur;
      if (!done_cur) begin
        case (phase_cur)
          cwd_pkg::PH_HIGH: begin
            first_nxt = rx_byte;
            crc_nxt   = cwd_pkg::crc8_byte(cwd_pkg::CRC_INIT, rx_byte);
          end
          cwd_pkg::PH_LOW: begin
            second_nxt = rx_byte;
            crc_nxt    = cwd_pkg::crc8_byte(crc_cur, rx_byte);
          end
          default: begin
            res_valid = 1'b1;
            crc_nxt   = cwd_pkg::CRC_INIT;
            if (ok) begin
              cnt_nxt = cnt_inc[cwd_pkg::CNT_W-1:0];
            end
            if (last) begin
              done_nxt = 1'b1;
            end
          end
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= cwd_pkg::PH_HIGH;
      first_r      <= '0;
      second_r     <= '0;
      crc_r        <= cwd_pkg::CRC_INIT;
      cnt_r        <= '0;
      done_r       <= 1'b1;
      word_count_r <= cwd_pkg::WORD_COUNT_RST;
    end else begin
      phase_r  <= phase_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      crc_r    <= crc_nxt;
      cnt_r    <= cnt_nxt;
      done_r   <= done_nxt;
      if (cfg_wr_en) begin
        word_count_r <= cfg_wr_data;
      end
    end
  end

endmodule

// ===== sv/cwd_out_reg.sv =====
`timescale 1ns / 1ps

module cwd_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  cwd_pkg::result_t load_data,
  input  logic             out_ready,
  output logic             out_valid,
  output cwd_pkg::result_t out_data,
  output logic             can_load
);

  logic             valid_r, valid_nxt;
  cwd_pkg::result_t data_r;

  // Free when empty or when the held word leaves this cycle
  assign can_load = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== sv/crc_checked_word_deframer.sv =====
`timescale 1ns / 1ps
// A word appears on the output in the cycle after its check byte is accepted.
// Throughput: one byte per cycle; in_ch.ready falls only while a finished word
// waits in the output register and out_ch.ready is low.
// Reset (synchronous, rst_n low): idle until a frame start, CRC 0xFF,
// word counter 0, word_count 9, output register empty.

module crc_checked_word_deframer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [cwd_pkg::CNT_W-1:0] cfg_wr_data,
  cwd_in_if.sink                    in_ch,
  cwd_out_if.source                 out_ch
);

  logic             acc;
  logic             can_load;
  logic             res_valid;
  cwd_pkg::result_t res;
  cwd_pkg::result_t out_data;

  assign in_ch.ready = can_load;
  assign acc         = in_ch.valid && can_load;

  // Byte grouping, CRC and frame tracking
  cwd_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .acc         (acc),
    .rx_byte     (in_ch.rx_byte),
    .frame_start (in_ch.frame_start),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Result register
  cwd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .load_data (res),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_data  (out_data),
    .can_load  (can_load)
  );

  assign out_ch.word_value    = out_data.word_value;
  assign out_ch.word_position = out_data.word_position;
  assign out_ch.crc_ok        = out_data.crc_ok;
  assign out_ch.last_word     = out_data.last_word;

  // A failed check always closes the frame
  a_fail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.crc_ok |-> out_ch.last_word)
    else $error("CRC failure not marked as last word");

  // Input stalls only behind a held, untaken word
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready)
    else $error("input stalled without a pending output word");

  // Output register is empty straight after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_ch.valid)
    else $error("output valid right after reset");

endmodule

// ===== dv/cwd_word_checker.sv =====
`timescale 1ns / 1ps

// Watches the byte, word and configuration ports of the deframer. It predicts
// every word from the accepted bytes and compares it with what leaves the block.
module cwd_word_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [cwd_pkg::CNT_W-1:0] cfg_wr_data,
  cwd_in_if                         byte_mon,
  cwd_out_if                        word_mon,
  output int                        mismatches,
  output int                        words_pending,
  output int                        words_checked,
  output int                        crc_bad_words
);

  localparam int REPORT_MAX = 10;

  // Predictor state
  logic [cwd_pkg::CNT_W-1:0] word_count_q;
  cwd_pkg::phase_t           phase_q;
  logic [7:0]                hi_q;
  logic [7:0]                lo_q;
  logic [7:0]                crc_q;
  logic [cwd_pkg::CNT_W-1:0] words_done_q;
  logic                      idle_q;

  // Predicted words not yet seen on the output
  cwd_pkg::result_t words_due[$];

  // CRC-8 register update, one data bit at a time
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] d);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ d[i];
      r  = {r[6:0], 1'b0} ^ (fb ? cwd_pkg::CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  // Words per frame after clamping the register to 1..MAX_WORDS
  function automatic int frame_words();
    int n;
    n = int'(word_count_q);
    if (n == 0) n = 1;
    if (n > int'(cwd_pkg::MAX_WORDS)) n = int'(cwd_pkg::MAX_WORDS);
    return n;
  endfunction

  // One accepted byte through the deframer
  task automatic deframe_byte(input logic [7:0] b, input logic fs);
    cwd_pkg::result_t w;
    logic             ok;
    if (fs) begin
      phase_q      = cwd_pkg::PH_HIGH;
      crc_q        = cwd_pkg::CRC_INIT;
      words_done_q = '0;
      idle_q       = 1'b0;
    end
    if (!idle_q) begin
      case (phase_q)
        cwd_pkg::PH_HIGH: begin
          hi_q    = b;
          crc_q   = crc8_next(cwd_pkg::CRC_INIT, b);
          phase_q = cwd_pkg::PH_LOW;
        end
        cwd_pkg::PH_LOW: begin
          lo_q    = b;
          crc_q   = crc8_next(crc_q, b);
          phase_q = cwd_pkg::PH_CHECK;
        end
        default: begin
          // check byte: word goes out whatever the CRC says
          ok              = (crc_q == b);
          w.word_value    = {hi_q, lo_q};
          w.word_position = words_done_q[cwd_pkg::POS_W-1:0];
          w.crc_ok        = ok;
          w.last_word     = !ok || (int'(words_done_q) + 1 >= frame_words());
          if (ok) words_done_q = words_done_q + 1'b1;
          if (w.last_word) idle_q = 1'b1;
          phase_q = cwd_pkg::PH_HIGH;
          crc_q   = cwd_pkg::CRC_INIT;
          words_due.push_back(w);
        end
      endcase
    end
  endtask

  // Compare one output transaction with the oldest prediction
  task automatic check_word(input cwd_pkg::result_t got);
    cwd_pkg::result_t want;
    if (words_due.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("[%0t] unexpected word: value %h pos %0d ok %b last %b", $realtime,
                 got.word_value, got.word_position, got.crc_ok, got.last_word);
    end else begin
      want = words_due.pop_front();
      words_checked++;
      if (!got.crc_ok) crc_bad_words++;
      if (got.word_value !== want.word_value || got.word_position !== want.word_position ||
          got.crc_ok !== want.crc_ok || got.last_word !== want.last_word) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display({"[%0t] word mismatch: exp value %h pos %0d ok %b last %b, ",
                    "got value %h pos %0d ok %b last %b"},
                   $realtime, want.word_value, want.word_position, want.crc_ok,
                   want.last_word, got.word_value, got.word_position, got.crc_ok,
                   got.last_word);
      end
    end
  endtask

  // Sample all ports on the rising edge
  always @(posedge clk) begin : monitor
    cwd_pkg::result_t got;
    if (!rst_n) begin
      word_count_q = cwd_pkg::WORD_COUNT_RST;
      phase_q      = cwd_pkg::PH_HIGH;
      hi_q         = '0;
      lo_q         = '0;
      crc_q        = cwd_pkg::CRC_INIT;
      words_done_q = '0;
      idle_q       = 1'b1;
      words_due.delete();
    end else begin
      if (word_mon.valid && word_mon.ready) begin
        got.word_value    = word_mon.word_value;
        got.word_position = word_mon.word_position;
        got.crc_ok        = word_mon.crc_ok;
        got.last_word     = word_mon.last_word;
        check_word(got);
      end
      if (cfg_wr_en) word_count_q = cfg_wr_data;
      if (byte_mon.valid && byte_mon.ready)
        deframe_byte(byte_mon.rx_byte, byte_mon.frame_start);
    end
    words_pending = words_due.size();
  end

endmodule

// ===== dv/tb_crc_checked_word_deframer.sv =====
`timescale 1ns / 1ps

// Drives response bytes and the word count into the deframer, with random
// gaps on both channels, and gives the verdict from the checker's counts.
module tb_crc_checked_word_deframer;

  localparam int STALL_LIMIT     = 4000;
  localparam int BYTES_PER_PHASE = 410;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_wr_en;
  logic [cwd_pkg::CNT_W-1:0] cfg_wr_data;

  cwd_in_if  byte_ch ();
  cwd_out_if word_ch ();

  int mismatches;
  int words_pending;
  int words_checked;
  int crc_bad_words;

  int send_idle_pct;
  int recv_stall_pct;
  int stall_cycles;
  int bytes_sent;
  int count_writes;
  logic [cwd_pkg::CNT_W-1:0] wc_now;

  crc_checked_word_deframer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch      (byte_ch),
    .out_ch     (word_ch)
  );

  cwd_word_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .byte_mon     (byte_ch),
    .word_mon     (word_ch),
    .mismatches   (mismatches),
    .words_pending(words_pending),
    .words_checked(words_checked),
    .crc_bad_words(crc_bad_words)
  );

  // 250 MHz clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver back-pressure
  initial begin
    word_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      word_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((byte_ch.valid && byte_ch.ready) || (word_ch.valid && word_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // Frame length the block will use for the current register value
  function automatic int words_per_frame();
    int n;
    n = int'(wc_now);
    if (n == 0) n = 1;
    if (n > int'(cwd_pkg::MAX_WORDS)) n = int'(cwd_pkg::MAX_WORDS);
    return n;
  endfunction

  // One byte transaction, with an optional random gap in front
  task automatic push_byte(input logic [7:0] b, input logic fs);
    if ($urandom_range(99) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    byte_ch.valid       <= 1'b1;
    byte_ch.rx_byte     <= b;
    byte_ch.frame_start <= fs;
    do @(posedge clk); while (!byte_ch.ready);
    bytes_sent++;
  endtask

  // High byte, low byte and check byte; flip corrupts the check byte
  task automatic send_word(input logic [7:0] hi, input logic [7:0] lo, input logic fs,
                           input logic [7:0] flip);
    push_byte(hi, fs);
    push_byte(lo, 1'b0);
    push_byte(cwd_pkg::crc8_byte(cwd_pkg::crc8_byte(cwd_pkg::CRC_INIT, hi), lo) ^ flip,
              1'b0);
  endtask

  // Wait until every predicted word has left the block
  task automatic settle();
    byte_ch.valid <= 1'b0;
    do @(negedge clk); while (words_pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_count(input logic [cwd_pkg::CNT_W-1:0] v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    wc_now = v;
    count_writes++;
  endtask

  // Mostly short frames, now and then the longest
  function automatic logic [cwd_pkg::CNT_W-1:0] pick_count();
    case ($urandom_range(3))
      0:       return cwd_pkg::CNT_W'($urandom_range(0, 31));
      3:       return cwd_pkg::CNT_W'(cwd_pkg::MAX_WORDS);
      default: return cwd_pkg::CNT_W'($urandom_range(1, 4));
    endcase
  endfunction

  // A whole frame, sometimes with a bad CRC, cut short or running past its end
  task automatic run_frame();
    int n;
    int kind;
    int bad_at;
    int cut_at;
    int extra;
    n      = words_per_frame();
    kind   = $urandom_range(99);
    bad_at = (kind < 25) ? $urandom_range(n - 1) : -1;
    cut_at = (kind >= 25 && kind < 35) ? $urandom_range(n - 1) : -1;
    extra  = (kind >= 85) ? $urandom_range(1, 2) : 0;
    for (int w = 0; w < n + extra; w++) begin
      if (w == cut_at) begin
        // partial word, abandoned by the next frame start
        push_byte(8'($urandom), w == 0);
        if ($urandom_range(1) == 1) push_byte(8'($urandom), 1'b0);
        break;
      end
      send_word(8'($urandom), 8'($urandom), w == 0,
                (w == bad_at) ? 8'($urandom_range(1, 255)) : 8'h00);
    end
    repeat ($urandom_range(0, 2)) push_byte(8'($urandom), 1'b0);
  endtask

  // Loose bytes, some with a frame start
  task automatic run_noise();
    repeat ($urandom_range(1, 6)) push_byte(8'($urandom), $urandom_range(99) < 25);
  endtask

  initial begin : stimulus
    rst_n               <= 1'b0;
    cfg_wr_en           <= 1'b0;
    cfg_wr_data         <= '0;
    byte_ch.valid       <= 1'b0;
    byte_ch.rx_byte     <= '0;
    byte_ch.frame_start <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wc_now         = cwd_pkg::WORD_COUNT_RST;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: bytes before any frame start are dropped
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    // count lowered mid-frame: the next good word closes it
    send_word(8'hFF, 8'h00, 1'b1, 8'h00);
    write_count(5'd1);
    send_word(8'h00, 8'hFF, 1'b0, 8'h00);
    push_byte(8'hA5, 1'b0);
    // zero behaves as one; a bad CRC ends the frame
    write_count(5'd0);
    send_word(8'h00, 8'h00, 1'b1, 8'h80);
    push_byte(8'h5A, 1'b0);
    // frame start in the middle of a word, then a failing second word
    write_count(5'd2);
    push_byte(8'h12, 1'b1);
    push_byte(8'h34, 1'b0);
    send_word(8'h12, 8'h34, 1'b1, 8'h00);
    send_word(8'hC3, 8'h3C, 1'b0, 8'h01);

    // Random: receiver-stall, sender-idle and full-rate phases
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct  = (mode == 0) ? 18 : (mode == 1) ? 71 : 0;
      recv_stall_pct = (mode == 0) ? 71 : (mode == 1) ? 18 : 0;
      write_count((mode == 0) ? cwd_pkg::CNT_W'(cwd_pkg::MAX_WORDS) :
                  (mode == 1) ? 5'd31 : 5'd3);
      while (bytes_sent < (mode + 1) * BYTES_PER_PHASE) begin
        if ($urandom_range(99) < 12) write_count(pick_count());
        if ($urandom_range(99) < 80) begin
          run_frame();
        end else begin
          run_noise();
        end
      end
    end

    settle();
    repeat (8) @(posedge clk);
    @(negedge clk);
    $display("Covered %0d bytes, %0d words checked (%0d with a bad CRC), %0d count writes",
             bytes_sent, words_checked, crc_bad_words, count_writes);
    $display("Idle, abandoned, overlong and noisy frames; word counts from 0 to 31");
    if (mismatches == 0 && words_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
